// ===== src/conveyor_color_reject_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// Conveyor colour reject sequencer: assertion macros
// Shared property forms for the sequencer and its remainder unit.
// ----------------------------------------------------------------------------
`ifndef CONVEYOR_COLOR_REJECT_SEQUENCER_ASSERT_SVH
`define CONVEYOR_COLOR_REJECT_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CCRS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define CCRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ccrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Conveyor colour reject sequencer: package
// Register map, reset values, speed codes, phase and sequencer types.
// ----------------------------------------------------------------------------
package ccrs_pkg;

	localparam int POSITION_BITS_DEF = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// Width of the small signed offset added to the position for a new target
	localparam int TGT_K_W = 15;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REVOLUTION = 3'd0,
		CFG_SECOND_HOOK = 3'd1,
		CFG_VISION_TOP = 3'd2,
		CFG_TOLERANCE = 3'd3,
		CFG_EJECT = 3'd4,
		CFG_COOLDOWN = 3'd5,
		CFG_MIN_COVERAGE = 3'd6,
		CFG_LEFT_LIMIT = 3'd7
	} cfg_reg_t;

	localparam logic [11:0] RST_REVOLUTION   = 12'd1480;
	localparam logic [11:0] RST_SECOND_HOOK  = 12'd760;
	localparam logic [11:0] RST_VISION_TOP   = 12'd360;
	localparam logic [9:0]  RST_TOLERANCE    = 10'd50;
	localparam logic [11:0] RST_EJECT        = 12'd100;
	localparam logic [11:0] RST_COOLDOWN     = 12'd200;
	localparam logic [8:0]  RST_MIN_COVERAGE = 9'd160;
	localparam logic [8:0]  RST_LEFT_LIMIT   = 9'd80;

	localparam logic signed [8:0] SPEED_NONE    = 9'sd0;
	localparam logic signed [8:0] SPEED_SLOW    = 9'sd150;
	localparam logic signed [8:0] SPEED_REVERSE = -9'sd200;
	localparam logic signed [8:0] SPEED_FORWARD = 9'sd200;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_IN_VIEW = 3'd1,
		PH_TRANSPORT = 3'd2,
		PH_EJECT = 3'd3,
		PH_RECOVER = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_MOD,
		SEQ_SUM
	} seq_t;

	// Status of the remainder unit
	typedef struct packed {
		logic busy;
		logic done;
	} mod_st_t;

endpackage

// ===== src/ccrs_if.sv =====
// ----------------------------------------------------------------------------
// Conveyor colour reject sequencer: channel interfaces
// Tick channel in and result channel out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ccrs_in_if #(parameter int PB = ccrs_pkg::POSITION_BITS_DEF);
	logic                 valid;
	logic                 ready;
	logic                 conveyor_forward;
	logic                 keep_blue;
	logic [8:0]           red_width;
	logic signed [9:0]    red_left;
	logic [8:0]           blue_width;
	logic signed [9:0]    blue_left;
	logic signed [PB-1:0] motor_position;

	modport source (output valid, conveyor_forward, keep_blue, red_width, red_left,
		blue_width, blue_left, motor_position, input ready);
	modport sink (input valid, conveyor_forward, keep_blue, red_width, red_left,
		blue_width, blue_left, motor_position, output ready);
endinterface

interface ccrs_out_if #(parameter int PB = ccrs_pkg::POSITION_BITS_DEF);
	logic                 valid;
	logic                 ready;
	logic [2:0]           sort_phase;
	logic                 speed_valid;
	logic signed [8:0]    speed_rpm;
	logic signed [PB-1:0] target_position;

	modport source (output valid, sort_phase, speed_valid, speed_rpm, target_position,
		input ready);
	modport sink (input valid, sort_phase, speed_valid, speed_rpm, target_position,
		output ready);
endinterface

// ===== src/ccrs_mod_unit.sv =====
// ----------------------------------------------------------------------------
// Conveyor colour reject sequencer: floor-mod unit
// Bit-serial restoring remainder of a signed position by a 12-bit length.
// ----------------------------------------------------------------------------
module ccrs_mod_unit #(
	parameter int PB = ccrs_pkg::POSITION_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [PB-1:0]  dividend,
	input  logic [11:0]           rev,
	output logic [11:0]           off,
	output ccrs_pkg::mod_st_t     st
);
	import ccrs_pkg::*;

	localparam int CNT_W = $clog2(PB);

	logic [PB-1:0]    mag_q;
	logic [11:0]      r_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [12:0] trial;
	logic        take;
	logic [11:0] r_nxt;

	// One quotient bit per cycle, most significant first
	assign trial = {r_q, mag_q[PB-1]};
	assign take  = trial >= {1'b0, rev};
	assign r_nxt = take ? 12'(trial - {1'b0, rev}) : trial[11:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(PB - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[PB-1];
			mag_q <= dividend[PB-1] ? PB'(-dividend) : PB'(dividend);
			r_q   <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[PB-2:0], 1'b0};
			r_q   <= r_nxt;
		end
	end

	// Fold the magnitude remainder back to a floor remainder
	always_comb begin
		if (rev == '0) begin
			off = '0;
		end else if (neg_q && r_q != '0) begin
			off = rev - r_q;
		end else begin
			off = r_q;
		end
	end

	assign st.busy = busy_q;
	assign st.done = done_q;

	`include "conveyor_color_reject_sequencer_assert.svh"

	`CCRS_ASSERT_SAME(a_busy_done_excl, busy_q, !done_q, "busy and done together")
	`CCRS_ASSERT_SAME(a_start_idle, start, !busy_q && !done_q, "start while working")
	`CCRS_ASSERT_NEXT(a_start_busy, start, busy_q, "start did not raise busy")
	`CCRS_ASSERT_SAME(a_rem_range, busy_q && rev != '0, r_q < rev, "remainder out of range")

endmodule

// ===== src/conveyor_color_reject_sequencer.sv =====
// ----------------------------------------------------------------------------
// Conveyor colour reject sequencer: top level
// Five-phase reject sequence per poll tick, with stop target computation.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  item      in   item.valid/ready       forward, colour, detections, position
//  result    out  result.valid/ready     phase, speed command, stop target
//  cfg       in   cfg_we                 cfg_index, cfg_data (8 registers)
//
//  A tick's result is registered the cycle after it is accepted, except the
//  tick on which the unwanted item leaves view: that one goes through the
//  bit-serial remainder unit, one position bit a cycle, and then a target sum
//  step. One tick is in work at a time; the next beat is taken in the cycle its
//  result is taken. Reset clears the phase to idle, the target to zero and
//  loads the register defaults. A stalled result holds all state.
// ----------------------------------------------------------------------------
module conveyor_color_reject_sequencer #(
	parameter int POSITION_BITS = ccrs_pkg::POSITION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ccrs_in_if.sink                         item,
	ccrs_out_if.source                      result,
	input  logic                            cfg_we,
	input  logic [ccrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ccrs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ccrs_pkg::*;

	localparam int PB = POSITION_BITS;
	localparam int KW = TGT_K_W;

	// Configuration registers
	logic [11:0] rev_q;
	logic [11:0] hook2_q;
	logic [11:0] vtop_q;
	logic [9:0]  tol_q;
	logic [11:0] eject_q;
	logic [11:0] cool_q;
	logic [8:0]  mincov_q;
	logic [8:0]  leftlim_q;

	// Sequence state
	phase_t               phase_q;
	logic signed [PB-1:0] tgt_q;
	seq_t                 seq_q;
	seq_t                 seq_nxt;

	// Held across the remainder pass
	logic signed [PB-1:0] pos_q;
	logic signed [KW-1:0] k_q;

	// Result register
	logic                 out_valid_q;
	logic                 spd_valid_q;
	logic signed [8:0]    spd_q;

	logic                 in_ready;
	logic                 fire;
	logic                 mod_start;
	logic [11:0]          mod_off;
	mod_st_t              mod_st;

	logic [8:0]           sel_width;
	logic signed [10:0]   sel_left;
	logic                 leaving;
	logic                 need_mod;
	logic                 pos_ge;
	logic                 pos_le;
	logic signed [13:0]   eject_delta;
	logic signed [13:0]   cool_delta;

	phase_t               nxt_phase;
	logic signed [PB-1:0] nxt_tgt;
	logic                 nxt_spd_valid;
	logic signed [8:0]    nxt_spd;

	logic [12:0]          off_plus_tol;
	logic [11:0]          hook_add;
	logic signed [KW-1:0] k_nxt;

	// ------------------------------------------------------------------
	// Configuration writes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_q     <= RST_REVOLUTION;
			hook2_q   <= RST_SECOND_HOOK;
			vtop_q    <= RST_VISION_TOP;
			tol_q     <= RST_TOLERANCE;
			eject_q   <= RST_EJECT;
			cool_q    <= RST_COOLDOWN;
			mincov_q  <= RST_MIN_COVERAGE;
			leftlim_q <= RST_LEFT_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_REVOLUTION:   rev_q     <= cfg_data;
				CFG_SECOND_HOOK:  hook2_q   <= cfg_data;
				CFG_VISION_TOP:   vtop_q    <= cfg_data;
				CFG_TOLERANCE:    tol_q     <= cfg_data[9:0];
				CFG_EJECT:        eject_q   <= cfg_data;
				CFG_COOLDOWN:     cool_q    <= cfg_data;
				CFG_MIN_COVERAGE: mincov_q  <= cfg_data[8:0];
				CFG_LEFT_LIMIT:   leftlim_q <= cfg_data[8:0];
				default:          ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Tick decode: always watch the unwanted colour
	// ------------------------------------------------------------------
	assign fire      = item.valid && in_ready;
	assign sel_width = item.keep_blue ? item.red_width : item.blue_width;
	assign sel_left  = item.keep_blue ? 11'(item.red_left) : 11'(item.blue_left);
	assign leaving   = (sel_left > $signed({2'b00, leftlim_q}))
		&& (sel_left < $signed({2'b00, mincov_q}));
	assign need_mod  = item.conveyor_forward && phase_q == PH_IN_VIEW && leaving;

	assign pos_ge = item.motor_position >= tgt_q;
	assign pos_le = item.motor_position <= tgt_q;

	// Stop-target steps for the eject and recover entries
	assign eject_delta = $signed({3'b000, tol_q, 1'b0}) - $signed({2'b00, eject_q});
	assign cool_delta  = $signed({2'b00, cool_q}) - $signed({3'b000, tol_q, 1'b0});

	// Combinational phase step; the leaving-view step goes through the remainder
	always_comb begin
		nxt_phase     = phase_q;
		nxt_tgt       = tgt_q;
		nxt_spd_valid = 1'b0;
		nxt_spd       = SPEED_NONE;
		if (item.conveyor_forward) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (sel_width >= mincov_q) begin
						nxt_phase     = PH_IN_VIEW;
						nxt_spd_valid = 1'b1;
						nxt_spd       = SPEED_SLOW;
					end
				end
				PH_IN_VIEW: ;
				PH_TRANSPORT: begin
					if (pos_ge) begin
						nxt_phase     = PH_EJECT;
						nxt_spd_valid = 1'b1;
						nxt_spd       = SPEED_REVERSE;
						nxt_tgt       = tgt_q + PB'(eject_delta);
					end
				end
				PH_EJECT: begin
					if (pos_le) begin
						nxt_phase     = PH_RECOVER;
						nxt_spd_valid = 1'b1;
						nxt_spd       = SPEED_FORWARD;
						nxt_tgt       = tgt_q + PB'(cool_delta);
					end
				end
				PH_RECOVER: begin
					if (pos_ge) begin
						nxt_phase = PH_IDLE;
						nxt_tgt   = '0;
					end
				end
				default: nxt_phase = PH_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Hook choice: first hook, first hook next turn, or second hook
	// ------------------------------------------------------------------
	assign off_plus_tol = {1'b0, mod_off} + {3'b000, tol_q};

	always_comb begin
		if (mod_off < {2'b00, tol_q}) begin
			hook_add = '0;
		end else if (off_plus_tol > {1'b0, rev_q}) begin
			hook_add = rev_q;
		end else begin
			hook_add = hook2_q;
		end
	end

	assign k_nxt = $signed({3'b000, vtop_q}) - $signed({5'b00000, tol_q})
		+ $signed({3'b000, hook_add}) - $signed({3'b000, mod_off});

	ccrs_mod_unit #(.PB(PB)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (item.motor_position),
		.rev      (rev_q),
		.off      (mod_off),
		.st       (mod_st)
	);

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		seq_nxt = seq_q;
		unique case (seq_q)
			SEQ_IDLE: if (fire && need_mod) seq_nxt = SEQ_MOD;
			SEQ_MOD:  if (mod_st.done) seq_nxt = SEQ_SUM;
			SEQ_SUM:  seq_nxt = SEQ_IDLE;
			default:  seq_nxt = SEQ_IDLE;
		endcase
	end

	// Sequencer: outputs
	always_comb begin
		in_ready  = 1'b0;
		mod_start = 1'b0;
		unique case (seq_q)
			SEQ_IDLE: begin
				in_ready  = !out_valid_q || result.ready;
				mod_start = item.valid && in_ready && need_mod;
			end
			SEQ_MOD:  ;
			SEQ_SUM:  ;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= SEQ_IDLE;
			phase_q     <= PH_IDLE;
			tgt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			seq_q <= seq_nxt;
			if (fire && !need_mod) begin
				// Hold phase and target as the result of this beat
				phase_q     <= nxt_phase;
				tgt_q       <= nxt_tgt;
				out_valid_q <= 1'b1;
			end else if (seq_q == SEQ_SUM) begin
				phase_q     <= PH_TRANSPORT;
				tgt_q       <= pos_q + PB'(k_q);
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pos_q       <= item.motor_position;
			spd_valid_q <= need_mod ? 1'b0 : nxt_spd_valid;
			spd_q       <= need_mod ? SPEED_NONE : nxt_spd;
		end
		if (seq_q == SEQ_MOD && mod_st.done) begin
			k_q <= k_nxt;
		end
	end

	assign item.ready             = in_ready;
	assign result.valid           = out_valid_q;
	assign result.sort_phase      = phase_q;
	assign result.speed_valid     = spd_valid_q;
	assign result.speed_rpm       = spd_q;
	assign result.target_position = tgt_q;

	`include "conveyor_color_reject_sequencer_assert.svh"

	`CCRS_ASSERT_SAME(a_busy_no_result, seq_q != SEQ_IDLE, !out_valid_q,
		"result shown while a target is in work")
	`CCRS_ASSERT_NEXT(a_done_to_sum, mod_st.done, seq_q == SEQ_SUM,
		"remainder done without target sum")
	`CCRS_ASSERT_SAME(a_idle_target_zero, phase_q == PH_IDLE, tgt_q == '0,
		"idle phase with a live target")
	`CCRS_ASSERT_SAME(a_speed_phase, out_valid_q && spd_valid_q,
		phase_q == PH_IN_VIEW || phase_q == PH_EJECT || phase_q == PH_RECOVER,
		"speed command in a phase without one")

endmodule
